[rtl/core/g711x_pkg.sv]
package g711x_pkg;

    localparam logic [2:0] ENC_PCM8  = 3'd0;
    localparam logic [2:0] ENC_MULAW = 3'd1;
    localparam logic [2:0] ENC_ALAW  = 3'd2;
    localparam logic [2:0] ENC_PCM16 = 3'd3;
    localparam logic [2:0] ENC_PCM24 = 3'd4;
    localparam logic [2:0] ENC_PCM32 = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_MALFORMED = 2'd1;
    localparam logic [1:0] STAT_END_DROP  = 2'd2;

    localparam int QueueDepth = 2;

    // one result to be produced by the back end
    typedef struct packed {
        logic [2:0]  enc;
        logic [7:0]  data;
        logic [23:0] gathered;
        logic        last;
        logic [1:0]  status;
    } g711x_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } g711x_qstat_t;

endpackage

[rtl/core/g711x_if.sv]
interface g711x_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface g711x_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               sample_last;
    logic [1:0]         status;

    modport source (output valid, output sample, output sample_last, output status,
                    input ready);
    modport sink (input valid, input sample, input sample_last, input status,
                  output ready);
endinterface

[rtl/core/g711x_front.sv]
module g711x_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_last,
    input  g711x_pkg::g711x_qstat_t q_stat,
    output logic                push,
    output g711x_pkg::g711x_cmd_t   cmd
);
    import g711x_pkg::*;

    logic [2:0]  enc_reg;
    logic [23:0] gath_reg, gath_next;
    logic [1:0]  held_reg, held_next;
    logic [2:0]  need;
    logic        accept;
    logic        complete;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (enc_reg)
            ENC_PCM8, ENC_MULAW, ENC_ALAW: need = 3'd1;
            ENC_PCM16:                     need = 3'd2;
            ENC_PCM24:                     need = 3'd3;
            ENC_PCM32:                     need = 3'd4;
            default:                       need = 3'd0;
        endcase
    end

    assign complete = (need != 3'd0) && ({1'b0, held_reg} + 3'd1 == need);

    always_comb
    begin
        gath_next = gath_reg;
        held_next = held_reg;
        if (complete || in_last)
        begin
            gath_next = '0;
            held_next = '0;
        end
        else if (need != 3'd0)
        begin
            case (held_reg)
                2'd0:    gath_next[7:0]   = in_data;
                2'd1:    gath_next[15:8]  = in_data;
                default: gath_next[23:16] = in_data;
            endcase
            held_next = held_reg + 2'd1;
        end
    end

    assign push         = accept && (complete || in_last);
    assign cmd.enc      = enc_reg;
    assign cmd.data     = in_data;
    assign cmd.gathered = gath_reg;
    assign cmd.last     = in_last;
    assign cmd.status   = complete ? STAT_OK :
                          (enc_reg == ENC_PCM16) ? STAT_END_DROP : STAT_MALFORMED;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg  <= ENC_PCM16;
            gath_reg <= '0;
            held_reg <= '0;
        end
        else if (cfg_we)
        begin
            enc_reg  <= cfg_wdata;
            gath_reg <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            gath_reg <= gath_next;
            held_reg <= held_next;
        end
    end

endmodule

[rtl/core/g711x_queue.sv]
module g711x_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  g711x_pkg::g711x_cmd_t push_cmd,
    output g711x_pkg::g711x_qstat_t q_stat,
    input  logic                  pop_ready,
    output logic                  pop_valid,
    output g711x_pkg::g711x_cmd_t pop_cmd
);
    import g711x_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    g711x_cmd_t          slot_reg [QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW:0]       count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (count_reg == (PtrW+1)'(QueueDepth));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign pop_valid    = !q_stat.empty;
    assign do_pop       = pop_valid && pop_ready;
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/g711x_back.sv]
module g711x_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  g711x_pkg::g711x_cmd_t cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    out_sample,
    output logic                  out_last,
    output logic [1:0]            out_status
);
    import g711x_pkg::*;

    localparam logic [15:0] MuBias = 16'h0084;
    localparam logic [15:0] ABias  = 16'h0108;
    localparam logic [7:0]  AXor   = 8'h55;

    logic               valid_reg;
    logic signed [31:0] sample_reg, sample_next;
    logic               last_reg;
    logic [1:0]         status_reg;
    logic               take;

    logic [7:0]  mu_v, a_v;
    logic [15:0] mu_mag, a_mag;
    logic [31:0] mu_q, a_q;

    // mu-law expansion
    always_comb
    begin
        mu_v   = ~cmd.data;
        mu_mag = (({9'd0, mu_v[3:0], 3'd0} + MuBias) << mu_v[6:4]) - MuBias;
        mu_q   = mu_v[7] ? 32'd0 - {mu_mag, 16'd0} : {mu_mag, 16'd0};
    end

    // a-law expansion, sign bit set means positive
    always_comb
    begin
        a_v = cmd.data ^ AXor;
        if (a_v[6:4] == 3'd0)
        begin
            a_mag = {8'd0, a_v[3:0], 4'd0} + 16'd8;
        end
        else
        begin
            a_mag = ({8'd0, a_v[3:0], 4'd0} + ABias) << (a_v[6:4] - 3'd1);
        end
        a_q = a_v[7] ? {a_mag, 16'd0} : 32'd0 - {a_mag, 16'd0};
    end

    always_comb
    begin
        sample_next = '0;
        if (cmd.status == STAT_OK)
        begin
            case (cmd.enc)
                ENC_PCM8:  sample_next = {cmd.data ^ 8'h80, 24'd0};
                ENC_MULAW: sample_next = mu_q;
                ENC_ALAW:  sample_next = a_q;
                ENC_PCM16: sample_next = {cmd.data, cmd.gathered[7:0], 16'd0};
                ENC_PCM24: sample_next = {cmd.data, cmd.gathered[15:0], 8'd0};
                ENC_PCM32: sample_next = {cmd.data, cmd.gathered};
                default:   sample_next = '0;
            endcase
        end
    end

    assign cmd_ready  = !valid_reg || out_ready;
    assign take       = cmd_valid && cmd_ready;
    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample_next;
            last_reg   <= cmd.last;
            status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            valid_reg <= cmd_valid;
        end
    end

endmodule

[rtl/core/g711_pcm_sample_expander.sv]
// Expands a little-endian audio data byte stream into signed Q1.31 samples for
// unsigned PCM8, G.711 mu-law and A-law, and signed PCM16, PCM24 and PCM32,
// chosen by the 3-bit encoding register (reset value selects PCM16). One byte
// is taken per clock, sustained: the front end gathers bytes and hands each
// finished sample or end-of-data event to a two-entry queue, and the back end
// expands it into the output register, so a result passes through a queue entry
// and the output register before it is offered, and a stalled output holds off
// the input only once the queue fills. A final byte marks the last result;
// leftover PCM24/PCM32 bytes or a byte under an unused encoding give status 1,
// a dropped PCM16 byte gives status 2, all with sample 0.
// Writing the encoding register discards any partly gathered sample and must
// happen only while no transfer is in flight.
module g711_pcm_sample_expander (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_wdata,
    g711x_byte_if.sink            byte_in,
    g711x_sample_if.source        sample_out
);
    import g711x_pkg::*;

    g711x_qstat_t q_stat;
    g711x_cmd_t   push_cmd;
    g711x_cmd_t   pop_cmd;
    logic         push;
    logic         pop_valid;
    logic         pop_ready;

    g711x_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .in_data   (byte_in.data_byte),
        .in_last   (byte_in.end_of_data),
        .q_stat    (q_stat),
        .push      (push),
        .cmd       (push_cmd)
    );

    g711x_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_stat    (q_stat),
        .pop_ready (pop_ready),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    g711x_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .out_valid  (sample_out.valid),
        .out_ready  (sample_out.ready),
        .out_sample (sample_out.sample),
        .out_last   (sample_out.sample_last),
        .out_status (sample_out.status)
    );

    a_error_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.valid && sample_out.status != STAT_OK |-> sample_out.sample == 32'sd0)
        else $error("error result carries a nonzero sample");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.valid && sample_out.status != STAT_OK |-> sample_out.sample_last)
        else $error("error result does not close the stream");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> q_stat.full && !q_stat.empty)
        else $error("input stalled while queue has room");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> !q_stat.full || $past(push))
        else $error("queue full after a pop without a push");

endmodule

[test/testbench.sv]
module testbench;
    import g711x_pkg::*;

    // encoding codes with no format behind them
    localparam logic [2:0] ENC_SPARE6 = 3'd6;
    localparam logic [2:0] ENC_SPARE7 = 3'd7;

    localparam logic [31:0] MU_BIAS = 32'h84;
    localparam logic [31:0] A_BIAS  = 32'h108;
    localparam logic [7:0]  A_XOR   = 8'h55;

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 50;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
        logic [1:0]         status;
    } sample_result_t;

    typedef struct packed {
        logic           wr_enc;
        logic [2:0]     enc;
        logic [7:0]     data;
        logic           eod;
        logic           typed;
        sample_result_t want;
    } directed_row_t;

    localparam sample_result_t NO_RESULT = '{32'sd0, 1'b0, STAT_OK};

    localparam directed_row_t DIRECTED [0:24] = '{
        '{1'b0, ENC_PCM16,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM16,  8'h80, 1'b0, 1'b1, '{32'h80000000, 1'b0, STAT_OK}},
        '{1'b0, ENC_PCM16,  8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM16,  8'h7F, 1'b1, 1'b1, '{32'h7FFF0000, 1'b1, STAT_OK}},
        '{1'b0, ENC_PCM16,  8'hAB, 1'b1, 1'b1, '{32'h00000000, 1'b1, STAT_END_DROP}},
        '{1'b1, ENC_PCM8,   8'h00, 1'b0, 1'b1, '{32'h80000000, 1'b0, STAT_OK}},
        '{1'b0, ENC_PCM8,   8'hFF, 1'b1, 1'b1, '{32'h7F000000, 1'b1, STAT_OK}},
        '{1'b1, ENC_MULAW,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_MULAW,  8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_MULAW,  8'h7F, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, ENC_ALAW,   8'h55, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_ALAW,   8'hD5, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_ALAW,   8'h2A, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, ENC_PCM24,  8'h01, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM24,  8'h02, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM24,  8'h03, 1'b0, 1'b1, '{32'h03020100, 1'b0, STAT_OK}},
        '{1'b0, ENC_PCM24,  8'h11, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM24,  8'h22, 1'b1, 1'b1, '{32'h00000000, 1'b1, STAT_MALFORMED}},
        '{1'b1, ENC_PCM32,  8'h44, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM32,  8'h33, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM32,  8'h22, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_PCM32,  8'h11, 1'b1, 1'b1, '{32'h11223344, 1'b1, STAT_OK}},
        '{1'b0, ENC_PCM32,  8'hEE, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, ENC_SPARE6, 8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, ENC_SPARE6, 8'hA5, 1'b1, 1'b1, '{32'h00000000, 1'b1, STAT_MALFORMED}}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    g711x_byte_if   byte_bus ();
    g711x_sample_if sample_bus ();

    g711_pcm_sample_expander DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_in    (byte_bus),
        .sample_out (sample_bus)
    );

    // expander state mirrored on the test side, plus the scoreboard and stimulus controls
    logic [2:0]     enc_now;
    logic [23:0]    gathered;
    logic [1:0]     held;
    sample_result_t pending_samples [$];
    int             mismatches;
    logic           burst_mode;
    int             hold_asks;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] to_q31(input logic negative, input logic [31:0] mag);
        logic [31:0] v;
        v = mag << 16;
        return negative ? -v : v;
    endfunction

    function automatic logic [31:0] mu_expand(input logic [7:0] b);
        logic [7:0]  v;
        logic [31:0] mag;
        v = ~b;
        mag = ((({28'd0, v[3:0]} << 3) + MU_BIAS) << v[6:4]) - MU_BIAS;
        return to_q31(v[7], mag);
    endfunction

    function automatic logic [31:0] a_expand(input logic [7:0] b);
        logic [7:0]  v;
        logic [31:0] mag;
        v = b ^ A_XOR;
        if (v[6:4] == 3'd0)
            mag = ({28'd0, v[3:0]} << 4) + 32'd8;
        else
            mag = (({28'd0, v[3:0]} << 4) + A_BIAS) << (v[6:4] - 3'd1);
        // sign bit set means positive in a-law
        return to_q31(!v[7], mag);
    endfunction

    function automatic logic expand_byte(input logic [7:0] b, input logic eod,
                                         output sample_result_t r);
        logic [2:0] need;
        case (enc_now)
            ENC_PCM8, ENC_MULAW, ENC_ALAW: need = 3'd1;
            ENC_PCM16: need = 3'd2;
            ENC_PCM24: need = 3'd3;
            ENC_PCM32: need = 3'd4;
            default:   need = 3'd0;
        endcase
        r = NO_RESULT;
        if (need != 3'd0 && held + 1 == need)
        begin
            case (enc_now)
                ENC_PCM8:  r.sample = {b ^ 8'h80, 24'd0};
                ENC_MULAW: r.sample = mu_expand(b);
                ENC_ALAW:  r.sample = a_expand(b);
                ENC_PCM16: r.sample = {b, gathered[7:0], 16'd0};
                ENC_PCM24: r.sample = {b, gathered[15:0], 8'd0};
                default:   r.sample = {b, gathered};
            endcase
            r.last = eod;
            r.status = STAT_OK;
            gathered = '0;
            held = '0;
            return 1'b1;
        end
        if (need != 3'd0)
        begin
            gathered = gathered | ({16'd0, b} << (8 * held));
            held = held + 2'd1;
        end
        if (!eod)
            return 1'b0;
        r.last = 1'b1;
        r.status = (enc_now == ENC_PCM16) ? STAT_END_DROP : STAT_MALFORMED;
        gathered = '0;
        held = '0;
        return 1'b1;
    endfunction

    task automatic write_encoding(input logic [2:0] value);
        byte_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        enc_now = value;
        gathered = '0;
        held = '0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eod, input logic typed,
                             input sample_result_t want);
        int             gap;
        sample_result_t got;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_bus.valid <= 1'b1;
        byte_bus.data_byte <= b;
        byte_bus.end_of_data <= eod;
        @(posedge clk);
        while (!byte_bus.ready)
            @(posedge clk);
        if (expand_byte(b, eod, got))
            pending_samples.push_back(typed ? want : got);
        else if (typed)
            pending_samples.push_back(want);
    endtask

    initial
    begin : byte_source
        logic [2:0] phase_enc;
        logic [7:0] b;
        logic       eod;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= ENC_PCM16;
        byte_bus.valid <= 1'b0;
        byte_bus.data_byte <= 8'h00;
        byte_bus.end_of_data <= 1'b0;
        enc_now = ENC_PCM16;
        gathered = '0;
        held = '0;
        mismatches = 0;
        burst_mode = 1'b0;
        hold_asks = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].wr_enc)
                write_encoding(DIRECTED[i].enc);
            send_byte(DIRECTED[i].data, DIRECTED[i].eod, DIRECTED[i].typed,
                      DIRECTED[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_enc = ENC_PCM8;
                1:       phase_enc = ENC_SPARE7;
                2:       phase_enc = ENC_PCM32;
                default: phase_enc = 3'($urandom_range(0, 5));
            endcase
            write_encoding(phase_enc);
            burst_mode = (p == 3 || p == 6);
            // long receiver hold-off while bytes keep coming
            if (p == 3 || p == 9)
                hold_asks++;
            for (int i = 0; i < PHASE_BYTES; i++)
            begin
                if (p == 4 && i == PHASE_BYTES / 2)
                begin
                    byte_bus.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_samples.size() != 0)
                        @(posedge clk);
                end
                b = 8'($urandom_range(0, 255));
                eod = ($urandom_range(0, 15) == 0) || (i == PHASE_BYTES - 1);
                send_byte(b, eod, 1'b0, NO_RESULT);
            end
        end
        burst_mode = 1'b0;

        byte_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin : sample_sink
        int             stall;
        int             hold;
        int             holds_done;
        sample_result_t want;
        sample_bus.ready <= 1'b0;
        stall = 0;
        hold = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (sample_bus.valid && sample_bus.ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    $display("%0t: unexpected transfer, sample %h last %b status %0d", $time,
                             sample_bus.sample, sample_bus.sample_last, sample_bus.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (sample_bus.sample !== want.sample)
                    begin
                        $display("%0t: sample expected %h actual %h", $time,
                                 want.sample, sample_bus.sample);
                        mismatches++;
                    end
                    if (sample_bus.sample_last !== want.last)
                    begin
                        $display("%0t: sample_last expected %b actual %b", $time,
                                 want.last, sample_bus.sample_last);
                        mismatches++;
                    end
                    if (sample_bus.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, sample_bus.status);
                        mismatches++;
                    end
                end
                stall = burst_mode ? 0 : $urandom_range(0, 4);
            end
            if (hold_asks > holds_done)
            begin
                holds_done++;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                sample_bus.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                sample_bus.ready <= 1'b0;
            end
            else
                sample_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

endmodule
